@@ rtl/core/mttl_pkg.sv @@
// package for the tile to latitude / longitude converter: formats and cordic angle tables
`default_nettype none
package mttl_pkg;

  localparam int IN_W  = 40;
  localparam int ZW    = 5;
  localparam int OUT_W = 31;
  localparam int WF    = 30;
  localparam int AW    = 40;  // internal signed q.30 datapath width

  localparam logic signed [AW-1:0] PI_W      = 40'sd3373259426;
  localparam logic signed [AW-1:0] PI_HALF_W = 40'sd1686629713;
  localparam logic signed [AW-1:0] LN2_W     = 40'sd744261118;
  localparam logic [31:0]          DEG_Q24   = 32'd961263669;

  typedef logic signed [AW-1:0] word_t;

  // atan / atanh(2^-i) from the power series in q.62, rounded half up to q.30
  // only ever evaluated for constant indices
  function automatic word_t series_angle(input int i, input bit hyp);
    logic [63:0] acc;
    logic [63:0] term;
    int n;
    acc = '0;
    n = 0;
    for (int p = 1; p < 64; p += 2) begin
      if (i > 0 && i * p <= 62) begin
        term = (64'd1 << (62 - i * p)) / 64'(p);
        if (!hyp && n[0]) acc = acc - term;
        else acc = acc + term;
        n = n + 1;
      end
    end
    return word_t'((acc + (64'd1 << 31)) >> 32);
  endfunction

  // atan(2^-i), q.30
  function automatic word_t atan_tab(input int i);
    word_t r;
    if (i == 0) r = (PI_W + 40'sd2) >>> 2;
    else r = series_angle(i, 1'b0);
    return r;
  endfunction

  // atanh(2^-i), q.30
  function automatic word_t atanh_tab(input int i);
    word_t r;
    r = series_angle(i, 1'b1);
    return r;
  endfunction

  // hyperbolic shift index of step n: 1,2,3,4,4,5,..,13,13,14,..
  function automatic int hyp_idx(input int n);
    int idx;
    int rep;
    idx = 1;
    rep = 4;
    for (int j = 0; j < 40; j++) begin
      if (j < n) begin
        if (idx == rep) rep = 3 * rep + 1;
        else idx = idx + 1;
      end
    end
    return idx;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/mercator_tile_to_lat_lon_top.sv @@
// top level: pipelined web mercator tile to latitude / longitude converter
//
//  channel | dir | tdata (low bit up)                 | tuser
//  s_axis  | in  | tile_x[39:0], tile_y[79:40], zoom  | -
//  m_axis  | out | latitude[30:0], longitude[61:31]   | -
//
// one beat per cycle sustained while m_axis keeps taking results; the depth is
// set by the two cordic chains (hyperbolic exp, circular vectoring), one step a stage
// the pipeline advances whenever the output register is empty or taken, so a
// stall on m_axis holds every stage in place and nothing is lost
// rst clears only the valid bits
`default_nettype none
module mercator_tile_to_lat_lon_top #(
  parameter int ZOOM_MAX        = 24,
  parameter int COORD_FRAC_BITS = 16,
  parameter int ANGLE_FRAC_BITS = 22,
  parameter int CORDIC_STAGES   = 24
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [87:0] s_axis_tdata,   // tile_x, tile_y, zoom, zero pad
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata    // latitude, longitude, zero pad
);
  import mttl_pkg::*;

  localparam int NS = CORDIC_STAGES;
  localparam int NP = 2 * NS + 8;           // total stages
  localparam int ZCW = 6;                   // holds zoom + frac bits (<= 40)

  logic adv;
  logic [NP-1:0] vld;
  assign adv = !vld[NP-1] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld[NP-1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[NP-2:0], s_axis_tvalid};
  end

  // ---------------- stage 0: capture, clamp zoom, form 2v-1 and longitude
  logic [IN_W-1:0] in_x, in_y;
  logic [ZW-1:0]   in_z, zcl;
  logic [ZCW-1:0]  zc;
  assign in_x = s_axis_tdata[39:0];
  assign in_y = s_axis_tdata[79:40];
  assign in_z = s_axis_tdata[84:80];
  assign zcl  = (in_z > ZW'(ZOOM_MAX)) ? ZW'(ZOOM_MAX) : in_z;
  assign zc   = ZCW'(zcl) + ZCW'(COORD_FRAC_BITS);

  // longitude: round(x*360*2^A / 2^zc) - 180*2^A, saturating when x >= 2^zc
  logic [IN_W+9:0] lx360;       // x*360
  logic [63:0]     lon_sc;
  logic signed [63:0] lon_v;
  logic [ZCW:0]    lsh;
  always_comb begin
    lx360 = (IN_W+10)'(in_x) * (IN_W+10)'(360);
    lsh = '0;
    if (ANGLE_FRAC_BITS >= zc) begin
      lsh = (ZCW+1)'(ANGLE_FRAC_BITS) - (ZCW+1)'(zc);
      lon_sc = 64'(lx360) << lsh;
    end else begin
      lsh = (ZCW+1)'(zc) - (ZCW+1)'(ANGLE_FRAC_BITS);
      lon_sc = (64'(lx360) + (64'd1 << (lsh - 1))) >> lsh;
    end
    if ((64'(in_x) >> zc) != 0) lon_v = 64'sd180 <<< ANGLE_FRAC_BITS;
    else lon_v = $signed(lon_sc) - (64'sd180 <<< ANGLE_FRAC_BITS);
    if (lon_v > 64'sd1073741823) lon_v = 64'sd1073741823;
    else if (lon_v < -64'sd1073741824) lon_v = -64'sd1073741824;
  end

  // w = clamp(2y - 2^zc, +-8*2^zc) rescaled to q.30
  logic signed [55:0] dd, lim;
  logic signed [AW-1:0] w_v;
  logic signed [55:0] dsh;
  always_comb begin
    dd  = $signed({15'd0, in_y, 1'b0}) - (56'sd1 <<< zc);
    lim = 56'sd8 <<< zc;
    if (dd > lim) dd = lim;
    if (dd < -lim) dd = -lim;
    dsh = '0;
    if (zc <= ZCW'(WF)) w_v = AW'(dd <<< (ZCW'(WF) - zc));
    else begin
      dsh = (dd + (56'sd1 <<< (zc - ZCW'(WF) - 1))) >>> (zc - ZCW'(WF));
      w_v = AW'(dsh);
    end
  end

  logic signed [OUT_W-1:0] lon_pipe [NP];
  logic signed [AW-1:0] s0_w;
  always_ff @(posedge clk) begin
    if (adv) begin
      s0_w <= w_v;
      lon_pipe[0] <= OUT_W'(lon_v);
      for (int i = 1; i < NP; i++) lon_pipe[i] <= lon_pipe[i-1];
    end
  end

  // ---------------- stage 1: split product |w|*pi
  logic neg1;
  logic [AW-1:0] mag0;
  logic [63:0] ph1, pl1;
  assign mag0 = s0_w[AW-1] ? AW'(-s0_w) : AW'(s0_w);
  always_ff @(posedge clk) begin
    if (adv) begin
      neg1 <= s0_w[AW-1];
      ph1  <= 64'(mag0 >> 16) * 64'(PI_W);
      pl1  <= 64'(mag0[15:0]) * 64'(PI_W);
    end
  end

  // ---------------- stage 2: t
  logic [63:0] q2;
  logic signed [AW-1:0] t_v, t2;
  assign q2  = ph1 + (pl1 >> 16);
  assign t_v = neg1 ? -AW'((q2 + 64'd8192) >> 14) : AW'((q2 + 64'd8192) >> 14);
  always_ff @(posedge clk) if (adv) t2 <= t_v;

  // ---------------- stage 3: k = floor((t + ln2/2)/ln2); |t| <= 8*pi so k in [-36,36]
  // done by compare against k*ln2 thresholds: tn = t + ln2/2 + 64*ln2 is positive
  logic signed [7:0] k_v, k3;
  logic signed [AW-1:0] tn, r_v, r3;
  always_comb begin
    tn  = t2 + (LN2_W >>> 1) + (LN2_W <<< 6);
    k_v = '0;
    for (int j = 1; j < 128; j++)
      if (tn >= AW'(j) * LN2_W) k_v = 8'(j);
    k_v = k_v - 8'sd64;
    r_v = t2 - AW'(k_v) * LN2_W;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      k3 <= k_v;
      r3 <= r_v;
    end
  end

  // k travels alongside the cordic
  logic signed [7:0] k_pipe [NS+1];
  always_ff @(posedge clk) begin
    if (adv) begin
      k_pipe[0] <= k3;
      for (int i = 1; i <= NS; i++) k_pipe[i] <= k_pipe[i-1];
    end
  end

  // ---------------- hyperbolic rotation chain
  word_t hx [NS+1], hy [NS+1], hz [NS+1];
  always_ff @(posedge clk) begin
    if (adv) begin
      hx[0] <= word_t'(64'sd1 <<< WF);
      hy[0] <= '0;
      hz[0] <= r3 >>> 1;
    end
  end
  for (genvar n = 0; n < NS; n++) begin : g_hyp
    localparam int IDX = hyp_idx(n);
    localparam word_t ATH = atanh_tab(IDX);
    always_ff @(posedge clk) begin
      if (adv) begin
        if (!hz[n][AW-1]) begin
          hx[n+1] <= hx[n] + (hy[n] >>> IDX);
          hy[n+1] <= hy[n] + (hx[n] >>> IDX);
          hz[n+1] <= hz[n] - ATH;
        end else begin
          hx[n+1] <= hx[n] - (hy[n] >>> IDX);
          hy[n+1] <= hy[n] - (hx[n] >>> IDX);
          hz[n+1] <= hz[n] + ATH;
        end
      end
    end
  end

  // ---------------- exp scaling by 2^k
  word_t cx [NS+1], cy [NS+1], ca [NS+1];
  word_t ex, ey;
  logic [5:0] kmag;
  always_comb begin
    ex = hx[NS] - hy[NS];
    ey = hx[NS] + hy[NS];
    kmag = k_pipe[NS][7] ? 6'(-k_pipe[NS]) : 6'(k_pipe[NS]);
    if (kmag > 6'd39) kmag = 6'd39;
    if (k_pipe[NS] > 0) ex = ex >>> kmag;
    else if (k_pipe[NS] < 0) ey = ey >>> kmag;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      cx[0] <= ex;
      cy[0] <= ey;
      ca[0] <= '0;
    end
  end

  // ---------------- circular vectoring chain
  for (genvar n = 0; n < NS; n++) begin : g_circ
    localparam word_t ATN = atan_tab(n);
    always_ff @(posedge clk) begin
      if (adv) begin
        if (!cy[n][AW-1]) begin
          cx[n+1] <= cx[n] + (cy[n] >>> n);
          cy[n+1] <= cy[n] - (cx[n] >>> n);
          ca[n+1] <= ca[n] + ATN;
        end else begin
          cx[n+1] <= cx[n] - (cy[n] >>> n);
          cy[n+1] <= cy[n] + (cx[n] >>> n);
          ca[n+1] <= ca[n] - ATN;
        end
      end
    end
  end

  // ---------------- degrees conversion: multiply, then round and clamp
  logic signed [AW-1:0] rad;
  logic signed [AW+33:0] prod;
  logic signed [AW+33:0] lat_r;
  logic signed [OUT_W-1:0] lat_o;
  localparam int SH = 24 + WF - ANGLE_FRAC_BITS;
  assign rad = PI_HALF_W - (ca[NS] <<< 1);
  always_ff @(posedge clk) if (adv) prod <= (AW+34)'(rad) * $signed({1'b0, DEG_Q24});
  always_comb begin
    lat_r = (prod + ((AW+34)'(1) <<< (SH - 1))) >>> SH;
    if (lat_r > 1073741823) lat_o = 31'sh3fffffff;
    else if (lat_r < -1073741824) lat_o = 31'sh40000000;
    else lat_o = OUT_W'(lat_r);
  end
  logic signed [OUT_W-1:0] lat_q;
  always_ff @(posedge clk) if (adv) lat_q <= lat_o;

  // stage count: in(1) mul(1) t(1) k(1) hyp-init(1) hyp(NS) circ-init(1) circ(NS) prod(1) out(1)
  assign m_axis_tdata = {2'b00, lon_pipe[NP-1], lat_q};

  property p_hold;
    @(posedge clk) disable iff (rst) (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid;
  endproperty
  a_hold: assert property (p_hold) else $error("output beat dropped under stall");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    (!m_axis_tvalid) |-> s_axis_tready) else $error("pipeline stalled while output empty");
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[63:62] == 2'b00)) else $error("pad bits set");

endmodule
`default_nettype wire

@@ dv/mercator_tile_to_lat_lon_top_tb.sv @@
// testbench for the tile to latitude / longitude converter
`timescale 1ns / 1ps
module mercator_tile_to_lat_lon_top_tb;
  import mttl_pkg::*;

  localparam int Z_MAX = 24;
  localparam int CFB   = 16;
  localparam int AFB   = 22;
  localparam int STG   = 24;
  localparam int LAT   = 2 * STG + 8;
  localparam longint PI_Q30   = 64'sd3373259426;
  localparam longint HPI_Q30  = 64'sd1686629713;
  localparam longint LN2_Q30  = 64'sd744261118;
  localparam longint RAD2DEG  = 64'sd961263669;
  localparam longint DEG_MAX  = 64'sd1073741823;
  localparam longint DEG_MIN  = -64'sd1073741824;

  typedef struct packed {
    logic signed [OUT_W-1:0] lat;
    logic signed [OUT_W-1:0] lon;
  } fix_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;

  fix_t   pending_fixes[$];
  int     mismatches;
  int     beats_in;
  int     beats_out;
  int     burst_left;
  bit     gaps_on;
  bit     stalls_on;
  int     hold_cycles;

  mercator_tile_to_lat_lon_top dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

  // atan(2^-i) or atanh(2^-i) in q.30 from the power series
  function automatic longint rot_angle(input int i, input bit hyp);
    longint unsigned acc;
    longint unsigned term;
    int p;
    int n;
    acc = 0;
    n = 0;
    if (!hyp && i == 0) return (PI_Q30 + 2) / 4;
    for (p = 1; i * p <= 62; p += 2) begin
      term = (64'd1 << (62 - i * p)) / p;
      if (!hyp && n[0]) acc -= term;
      else acc += term;
      n++;
    end
    return longint'((acc + (64'd1 << 31)) >> 32);
  endfunction

  function automatic longint clamp_deg(input longint v);
    if (v > DEG_MAX) return DEG_MAX;
    if (v < DEG_MIN) return DEG_MIN;
    return v;
  endfunction

  function automatic longint lon_deg(input longint unsigned x, input int zc);
    longint unsigned v;
    if (x >= (64'd1 << zc)) return 64'sd180 <<< AFB;
    v = x * 360;
    if (AFB >= zc) v = v << (AFB - zc);
    else v = (v + (64'd1 << (zc - AFB - 1))) >> (zc - AFB);
    return longint'(v) - (64'sd180 <<< AFB);
  endfunction

  function automatic longint lat_deg(input longint unsigned y, input int zc);
    longint span, d, w, t, k, r, hx, hy, hz, cx, cy, ang, a, dx, dy;
    longint unsigned mag, q;
    bit neg;
    int idx, rep;
    span = 64'sd1 <<< zc;
    d = 2 * longint'(y) - span;
    if (d > 8 * span) d = 8 * span;
    if (d < -8 * span) d = -8 * span;
    if (zc <= WF) w = d <<< (WF - zc);
    else w = (d + (64'sd1 <<< (zc - WF - 1))) >>> (zc - WF);
    neg = w < 0;
    mag = neg ? longint'(-w) : w;
    q = (mag >> 16) * PI_Q30 + (((mag & 64'hFFFF) * PI_Q30) >> 16);
    t = longint'((q + (64'd1 << 13)) >> 14);
    if (neg) t = -t;
    k = t + LN2_Q30 / 2;
    if (k >= 0) k = k / LN2_Q30;
    else k = -((-k + LN2_Q30 - 1) / LN2_Q30);
    r = t - k * LN2_Q30;
    // exp(r) via hyperbolic rotation, repeated steps at 4 and 13
    hx = 64'sd1 <<< WF;
    hy = 0;
    hz = r >>> 1;
    idx = 1;
    rep = 4;
    for (int n = 0; n < STG; n++) begin
      a = rot_angle(idx, 1'b1);
      dx = hy >>> idx;
      dy = hx >>> idx;
      if (hz >= 0) begin
        hx += dx; hy += dy; hz -= a;
      end else begin
        hx -= dx; hy -= dy; hz += a;
      end
      if (idx == rep) rep = 3 * rep + 1;
      else idx++;
    end
    cx = hx - hy;
    cy = hx + hy;
    if (k > 0) cx = cx >>> k;
    else if (k < 0) cy = cy >>> (-k);
    ang = 0;
    for (int n = 0; n < STG; n++) begin
      a = rot_angle(n, 1'b0);
      dx = cy >>> n;
      dy = cx >>> n;
      if (cy >= 0) begin
        cx += dx; cy -= dy; ang += a;
      end else begin
        cx -= dx; cy += dy; ang -= a;
      end
    end
    return ((HPI_Q30 - 2 * ang) * RAD2DEG + (64'sd1 <<< 31)) >>> 32;
  endfunction

  function automatic fix_t tile_to_deg(input logic [39:0] x, input logic [39:0] y,
                                       input logic [4:0] z);
    fix_t f;
    int zc;
    zc = ((z > Z_MAX) ? Z_MAX : int'(z)) + CFB;
    f.lat = OUT_W'(clamp_deg(lat_deg(y, zc)));
    f.lon = OUT_W'(clamp_deg(lon_deg(x, zc)));
    return f;
  endfunction

  // all drives happen at a rising edge
  task automatic send_beat(input logic [39:0] x, input logic [39:0] y, input logic [4:0] z);
    bit ok;
    fix_t f;
    f = tile_to_deg(x, y, z);
    s_axis_tdata  <= {3'b0, z, y, x};
    s_axis_tvalid <= 1'b1;
    do begin
      @(negedge clk);
      ok = s_axis_tready;
      @(posedge clk);
    end while (!ok);
    pending_fixes.push_back(f);
    beats_in++;
    if (gaps_on) begin
      if (burst_left == 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(1, 12);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic stop_input();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending_fixes.size() != 0) @(posedge clk);
  endtask

  function automatic logic [39:0] rand_coord(input int zc);
    logic [39:0] span;
    span = 40'd1 << zc;
    case ($urandom_range(0, 9))
      0: return 40'({$urandom, $urandom});
      1: return span - 40'($urandom_range(0, 3));
      2: return span + 40'($urandom_range(0, 3));
      3: return (span >> 1) + 40'($urandom_range(0, 4)) - 40'd2;
      4: return 40'($urandom_range(0, 3));
      default: return 40'({$urandom, $urandom}) & (span - 40'd1);
    endcase
  endfunction

  task automatic send_random(input int count);
    logic [4:0] z;
    int zc;
    repeat (count) begin
      z = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(25, 31)) : 5'($urandom_range(0, 24));
      zc = ((z > Z_MAX) ? Z_MAX : int'(z)) + CFB;
      send_beat(rand_coord(zc), rand_coord(zc), z);
    end
  endtask

  // corners: world edges, poles, equator, zoom extremes and above-max zoom
  task automatic test_directed();
    send_beat(40'd0, 40'd0, 5'd0);
    send_beat(40'd65535, 40'd65535, 5'd0);
    send_beat(40'd65536, 40'd65536, 5'd0);
    send_beat(40'd32768, 40'd32768, 5'd0);
    send_beat('1, '1, 5'd0);
    send_beat(40'd0, 40'd0, 5'd24);
    send_beat((40'd1 << 40) - 40'd1, (40'd1 << 39), 5'd24);
    send_beat((40'd1 << 39), (40'd1 << 39) - 40'd1, 5'd24);
    send_beat('1, '1, 5'd24);
    send_beat('1, 40'd0, 5'd31);
    send_beat(40'd12345, 40'd777, 5'd25);
    send_beat(40'd1 << 20, 40'd1 << 20, 5'd4);
    send_beat(40'd1 << 21, 40'd9 << 20, 5'd4);
    send_beat(40'd1, 40'd1, 5'd6);
    send_beat(40'h5555555555, 40'haaaaaaaaaa, 5'd24);
    send_beat(40'haaaaaaaaaa, 40'h5555555555, 5'd24);
    send_beat(40'd100, 40'd200000, 5'd1);
    send_beat(40'd3 << 30, 40'd5 << 30, 5'd16);
    stop_input();
    drain();
  endtask

  task automatic test_random_flow();
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    send_random(350);
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    send_random(150);
    stop_input();
  endtask

  // receiver holds off long enough for the pipeline to fill and push back
  task automatic test_backpressure();
    hold_cycles = 300;
    gaps_on = 1'b0;
    send_random(150);
    stop_input();
    drain();
    stalls_on = 1'b1;
    gaps_on = 1'b1;
    send_random(250);
    stop_input();
  endtask

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        hold_cycles--;
      end else if (stalls_on) begin
        m_axis_tready <= ($urandom_range(0, 99) < 60);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    fix_t want;
    fix_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.lat = m_axis_tdata[30:0];
      got.lon = m_axis_tdata[61:31];
      beats_out++;
      if (pending_fixes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat lat=%0d lon=%0d", got.lat, got.lon);
      end else begin
        want = pending_fixes.pop_front();
        if (got.lat !== want.lat || got.lon !== want.lon) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: lat exp %0d got %0d, lon exp %0d got %0d",
                     want.lat, got.lat, want.lon, got.lon);
        end
      end
    end
  end

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    mismatches    = 0;
    beats_in      = 0;
    beats_out     = 0;
    burst_left    = 0;
    gaps_on       = 1'b0;
    stalls_on     = 1'b0;
    hold_cycles   = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_flow();
    test_backpressure();
    drain();
    repeat (LAT + 20) @(posedge clk);
    if (pending_fixes.size() != 0) mismatches++;
    $display("converted %0d tile points to %0d lat/lon beats, zoom 0..31 incl. off-world tiles,",
             beats_in, beats_out);
    $display("with bursty input, random output stalls and a long output hold-off");
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
